### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the grid mass deposit block.
// Concurrent checks are compiled in unless SYNTH is defined.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define AST_IMP(lbl, clk, rst_n, ante, cons)
`define AST_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/gmd_pkg.sv
// Package for the grid mass deposit block: constants, register map and types.
// No dependencies.
package gmd_pkg;

	// Register map (index taken from paddr[2])
	localparam int unsigned PADDR_W = 3;
	localparam logic REG_CPU = 1'b0;

	// Reset value of cells_per_unit and of its square
	localparam logic [10:0] CPU_RESET = 11'd100;
	localparam logic [21:0] C2_RESET = 22'd10000;

	// Stream word widths
	localparam int unsigned S_TDATA_W = 96;
	localparam int unsigned M_TDATA_W = 72;

	// Saturation bounds
	localparam logic [47:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] SUM_MIN = 48'h8000_0000_0000;
	localparam logic [63:0] DENS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] DENS_MIN = 64'h8000_0000_0000_0000;

	// Request kinds carried on s_tuser
	typedef enum logic {
		REQ_DEPOSIT = 1'b0,
		REQ_READ    = 1'b1
	} req_t;

	// Per-item control that travels down the pipeline
	typedef struct packed {
		logic is_read;
		logic ok;
		logic sat;
		logic neg;
	} ctl_t;

endpackage

### hw/rtl/grid_mass_deposit.sv
// Grid mass deposit: each accepted word yields one result word.
// Throughput one word per cycle while m_tready is high; cell sums live in one
// synchronous memory, read-modify-written with forwarding between back-to-back hits.
// arst_n clears control state, then a clearing pass over all 2^(2*ceil(log2 GRID_DIM))
// entries (262144 at GRID_DIM 512) zeroes the memory with s_tready held low.
// Depends on gmd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module grid_mass_deposit #(
	parameter int GRID_DIM = 512
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// pos_x[19:0], pos_y[39:20], mass[71:40], cell_x[80:72], cell_y[89:81], zero pad
	input  logic [gmd_pkg::S_TDATA_W-1:0]    s_tdata,
	// req_type[0]
	input  logic                             s_tuser,
	// Result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// in_grid[0], density[64:1], saturated[65], zero pad
	output logic [gmd_pkg::M_TDATA_W-1:0]    m_tdata,
	// Configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [gmd_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int IW = (GRID_DIM > 2) ? $clog2(GRID_DIM) : 1;
	localparam int AW = 2 * IW;
	localparam int DEPTH = 1 << AW;
	localparam int OFFSET = (GRID_DIM / 2) * 65536;

	typedef struct packed {
		logic          ok;
		logic [IW-1:0] idx;
	} cidx_t;

	// Q16 coordinate to cell index, truncating toward zero
	function automatic cidx_t cell_of(input logic [31:0] t);
		cidx_t r;
		r.idx = t[16 +: IW];
		if (t[31]) begin
			r.ok = (t[31:16] == 16'hFFFF) && (t[15:0] != 16'd0);
			r.idx = '0;
		end else begin
			r.ok = (t[31:16] < 16'(GRID_DIM));
		end
		return r;
	endfunction

	// Configuration registers
	logic [10:0] cpu_q;
	logic [21:0] c2_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == gmd_pkg::REG_CPU);
	assign prdata = (paddr[2] == gmd_pkg::REG_CPU) ? {21'd0, cpu_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_q <= gmd_pkg::CPU_RESET;
			c2_q  <= gmd_pkg::C2_RESET;
		end else if (cfg_wr) begin
			cpu_q <= pwdata[10:0];
			c2_q  <= 22'(pwdata[10:0] * pwdata[10:0]);
		end
	end

	// Global pipeline advance: output register free or being taken
	logic advance, acc;
	logic m_valid_q;
	logic clr_q;
	logic [AW-1:0] clr_addr_q;

	assign advance  = !m_valid_q || m_tready;
	assign s_tready = advance && !clr_q;
	assign acc      = s_tvalid && s_tready;

	// Input word fields
	logic signed [19:0] in_px, in_py;
	logic signed [31:0] in_mass;
	logic [8:0]         in_cx, in_cy;

	assign in_px   = s_tdata[19:0];
	assign in_py   = s_tdata[39:20];
	assign in_mass = s_tdata[71:40];
	assign in_cx   = s_tdata[80:72];
	assign in_cy   = s_tdata[89:81];

	// Stage 1: scale positions by cells_per_unit
	logic               v_s1, read_s1;
	logic signed [31:0] px_s1, py_s1, mass_s1;
	logic [8:0]         cx_s1, cy_s1;

	always_ff @(posedge clk) begin
		if (advance) begin
			read_s1 <= (s_tuser == gmd_pkg::REQ_READ);
			px_s1   <= 32'(in_px * $signed({1'b0, cpu_q}));
			py_s1   <= 32'(in_py * $signed({1'b0, cpu_q}));
			mass_s1 <= in_mass;
			cx_s1   <= in_cx;
			cy_s1   <= in_cy;
		end
	end

	// Stage 1 comb: offset, truncate, range check, memory address
	logic [31:0]   tx, ty;
	cidx_t         cix, ciy;
	logic [9:0]    cx_ext, cy_ext;
	logic          rd_ok_s1;
	logic [AW-1:0] rd_addr;
	gmd_pkg::ctl_t ctl_in_s1;

	assign tx       = px_s1 + 32'(OFFSET);
	assign ty       = py_s1 + 32'(OFFSET);
	assign cix      = cell_of(tx);
	assign ciy      = cell_of(ty);
	assign cx_ext   = {1'b0, cx_s1};
	assign cy_ext   = {1'b0, cy_s1};
	assign rd_ok_s1 = ({2'b00, cx_s1} < 11'(GRID_DIM)) && ({2'b00, cy_s1} < 11'(GRID_DIM));
	assign rd_addr  = read_s1 ? {cx_ext[IW-1:0], cy_ext[IW-1:0]} : {cix.idx, ciy.idx};

	always_comb begin
		ctl_in_s1.is_read = read_s1;
		ctl_in_s1.ok      = read_s1 ? rd_ok_s1 : (cix.ok && ciy.ok);
		ctl_in_s1.sat     = 1'b0;
		ctl_in_s1.neg     = 1'b0;
	end

	// Stage 2: memory data, forwarding, accumulate and write back
	logic [47:0]        mem [DEPTH];
	logic [47:0]        rdata_s2;
	logic               v_s2;
	gmd_pkg::ctl_t      ctl_s2;
	logic [AW-1:0]      addr_s2;
	logic signed [31:0] mass_s2;
	logic               fwd_s2;
	logic [47:0]        fwd_data_s2;

	logic signed [47:0] base;
	logic signed [48:0] sum_wide;
	logic               dsat;
	logic [47:0]        new_sum;
	logic               we_pipe;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [47:0]        mem_wdata;

	assign base     = fwd_s2 ? fwd_data_s2 : rdata_s2;
	assign sum_wide = base + mass_s2;
	assign dsat     = sum_wide[48] != sum_wide[47];
	assign new_sum  = dsat ? (sum_wide[48] ? gmd_pkg::SUM_MIN : gmd_pkg::SUM_MAX)
	                       : sum_wide[47:0];
	assign we_pipe  = advance && v_s2 && !ctl_s2.is_read && ctl_s2.ok;

	assign mem_we    = clr_q || we_pipe;
	assign mem_waddr = clr_q ? clr_addr_q : addr_s2;
	assign mem_wdata = clr_q ? 48'd0 : new_sum;

	// Cell store: one write port, one registered read port (old data on collision)
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (advance) begin
			rdata_s2 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s2      <= ctl_in_s1;
			addr_s2     <= rd_addr;
			mass_s2     <= mass_s1;
			fwd_data_s2 <= new_sum;
		end
	end

	// Forward the sum written this cycle to the word reading the same cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s2 <= 1'b0;
		end else if (advance) begin
			fwd_s2 <= we_pipe && v_s1 && (addr_s2 == rd_addr);
		end
	end

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Stage 3: sign and magnitude of the sum for the density product
	logic          v_s3;
	gmd_pkg::ctl_t ctl_s3;
	logic [47:0]   mag_s3;

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s3.is_read <= ctl_s2.is_read;
			ctl_s3.ok      <= ctl_s2.ok;
			ctl_s3.sat     <= !ctl_s2.is_read && ctl_s2.ok && dsat;
			ctl_s3.neg     <= base[47];
			mag_s3         <= base[47] ? (48'd0 - base) : base;
		end
	end

	// Stage 4: two partial products against cells_per_unit squared
	logic          v_s4;
	gmd_pkg::ctl_t ctl_s4;
	logic [45:0]   pp_lo_s4, pp_hi_s4;

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s4   <= ctl_s3;
			pp_lo_s4 <= 46'(mag_s3[23:0] * c2_q);
			pp_hi_s4 <= 46'(mag_s3[47:24] * c2_q);
		end
	end

	// Stage 5: full product
	logic          v_s5;
	gmd_pkg::ctl_t ctl_s5;
	logic [69:0]   prod_s5;

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s5  <= ctl_s4;
			prod_s5 <= {pp_hi_s4, 24'd0} + 70'(pp_lo_s4);
		end
	end

	// Output stage: saturate and restore sign
	logic        over;
	logic [63:0] dens;
	logic        out_in_grid_q, out_sat_q;
	logic [63:0] out_density_q;

	assign over = (prod_s5[69:63] != 7'd0)
	           && !(ctl_s5.neg && (prod_s5[69:63] == 7'd1) && (prod_s5[62:0] == 63'd0));

	always_comb begin
		if (!ctl_s5.is_read || !ctl_s5.ok) begin
			dens = 64'd0;
		end else if (over) begin
			dens = ctl_s5.neg ? gmd_pkg::DENS_MIN : gmd_pkg::DENS_MAX;
		end else begin
			dens = ctl_s5.neg ? (64'd0 - prod_s5[63:0]) : prod_s5[63:0];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_in_grid_q <= ctl_s5.ok;
			out_density_q <= dens;
			out_sat_q     <= ctl_s5.is_read ? (ctl_s5.ok && over) : ctl_s5.sat;
		end
	end

	// Valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1      <= acc;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			m_valid_q <= v_s5;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, out_sat_q, out_density_q, out_in_grid_q};

	// Checks
	`AST_IMP(a_no_accept_in_clear, clk, arst_n, clr_q, !s_tready)
	`AST_IMP(a_clear_owns_write, clk, arst_n, we_pipe, !clr_q)
	`AST_IMP(a_dropped_zero, clk, arst_n, m_tvalid && !out_in_grid_q, out_density_q == 64'd0)
	`AST_NXT(a_fwd_taken, clk, arst_n, we_pipe && v_s1 && (addr_s2 == rd_addr), fwd_s2)

endmodule
